FILE: rtl/mstm_pkg.sv
`default_nettype none

package mstm_pkg;

  // Table geometry.
  localparam int unsigned Slots = 8;
  localparam int unsigned IdxW  = (Slots > 1) ? $clog2(Slots) : 1;

  // Field widths.
  localparam int unsigned TimeW   = 32;
  localparam int unsigned DelayW  = 20;
  localparam int unsigned CfgIdxW = 2;

  // Configuration reset values.
  localparam logic [DelayW-1:0] MinPeriodReset = 20'd1;
  localparam logic [DelayW-1:0] MaxPeriodReset = 20'd1000000;

  // Request operations.
  typedef enum logic [1:0] {
    OP_ARM     = 2'd0,
    OP_KILL    = 2'd1,
    OP_SERVICE = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_ARM   = 2'd0,
    KIND_KILL  = 2'd1,
    KIND_FIRE  = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_PERIOD = 2'd0,
    CFG_MAX_PERIOD = 2'd1
  } cfg_reg_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_FLUSH = 2'd2
  } state_e;

  // Command from the sequencer to the slot table.
  typedef struct packed {
    logic             arm_mode;
    logic             wr_arm;
    logic             wr_rearm;
    logic             wr_free;
    logic [TimeW-1:0] ident;
  } tbl_cmd_t;

  // What the slot table reports about the slot under the scan pointer.
  typedef struct packed {
    logic             free;
    logic             kill_hit;
    logic             due;
    logic             repeats;
    logic [TimeW-1:0] ident;
    logic [TimeW-1:0] tag;
  } tbl_view_t;

endpackage

`default_nettype wire

FILE: rtl/multi_slot_millisecond_timer.sv
// Arm and kill requests visit one slot per cycle until a free or matching slot
// is found or the last of the 8 slots is reached. A service request visits all
// 8 slots, one per cycle unless a due slot waits on the output, then the flush
// state. Each visit uses the single due-test subtract and deadline adder. Output
// stall holds the scan where a result must wait. Reset is asynchronous, active
// low: all slots free, next id 1, min_period 1, max_period 1000000.
`default_nettype none

module multi_slot_millisecond_timer (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // Request channel.
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire  [1:0]                         in_operation_i,
  input  wire  [mstm_pkg::TimeW-1:0]         in_now_i,
  input  wire  [mstm_pkg::DelayW-1:0]        in_delay_i,
  input  wire                                in_periodic_i,
  input  wire                                in_other_flags_i,
  input  wire  [mstm_pkg::TimeW-1:0]         in_user_tag_i,
  input  wire  [mstm_pkg::TimeW-1:0]         in_kill_id_i,
  // Result channel.
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic [1:0]                         out_kind_o,
  output logic                               out_status_o,
  output logic [mstm_pkg::TimeW-1:0]         out_timer_id_o,
  output logic [mstm_pkg::TimeW-1:0]         out_fired_tag_o,
  output logic                               out_last_o,
  // Configuration write channel.
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire  [mstm_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire  [mstm_pkg::DelayW-1:0]        cfg_data_i
);

  mstm_pkg::state_e state_q, state_d;

  // Captured request.
  mstm_pkg::op_e               op_q;
  logic                        bad_q;
  logic [mstm_pkg::TimeW-1:0]  now_q;
  logic [mstm_pkg::DelayW-1:0] delay_q;
  logic                        periodic_q;
  logic [mstm_pkg::TimeW-1:0]  tag_q;
  logic [mstm_pkg::TimeW-1:0]  kill_id_q;

  logic [mstm_pkg::DelayW-1:0] min_period_q;
  logic [mstm_pkg::DelayW-1:0] max_period_q;
  logic [mstm_pkg::TimeW-1:0]  next_ident_q;
  logic [mstm_pkg::TimeW-1:0]  next_ident_inc;
  logic [mstm_pkg::IdxW-1:0]   idx_q;
  logic                        last_slot;

  // Fire result held back until it is known whether another follows.
  logic                        pend_valid_q;
  logic [mstm_pkg::TimeW-1:0]  pend_id_q;
  logic [mstm_pkg::TimeW-1:0]  pend_tag_q;

  // Output register.
  logic                        out_valid_q;
  logic [1:0]                  out_kind_q, out_kind_d;
  logic                        out_status_q, out_status_d;
  logic [mstm_pkg::TimeW-1:0]  out_id_q, out_id_d;
  logic [mstm_pkg::TimeW-1:0]  out_tag_q, out_tag_d;
  logic                        out_last_q, out_last_d;

  logic                        in_accept;
  logic                        can_load;
  logic                        out_load;
  logic                        step;
  logic                        go_flush;
  logic                        go_idle;
  logic                        take_pend;
  logic                        clear_pend;
  logic                        bump_id;

  mstm_pkg::tbl_cmd_t          cmd;
  mstm_pkg::tbl_view_t         view;

  assign in_stall_o      = (state_q != mstm_pkg::S_IDLE);
  assign in_accept       = in_valid_i && !in_stall_o;
  assign cfg_ready_o     = 1'b1;
  assign can_load        = !out_valid_q || !out_stall_i;
  assign last_slot       = (idx_q == mstm_pkg::IdxW'(mstm_pkg::Slots - 1));
  assign next_ident_inc  = next_ident_q + 1'b1;

  assign out_valid_o     = out_valid_q;
  assign out_kind_o      = out_kind_q;
  assign out_status_o    = out_status_q;
  assign out_timer_id_o  = out_id_q;
  assign out_fired_tag_o = out_tag_q;
  assign out_last_o      = out_last_q;

  mstm_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .idx_i      (idx_q),
    .cmd_i      (cmd),
    .now_i      (now_q),
    .delay_i    (delay_q),
    .periodic_i (periodic_q),
    .tag_i      (tag_q),
    .kill_id_i  (kill_id_q),
    .view_o     (view)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_period_q <= mstm_pkg::MinPeriodReset;
      max_period_q <= mstm_pkg::MaxPeriodReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (mstm_pkg::cfg_reg_e'(cfg_index_i))
        mstm_pkg::CFG_MIN_PERIOD: min_period_q <= cfg_data_i;
        mstm_pkg::CFG_MAX_PERIOD: max_period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Request capture; the range and flag check is settled on acceptance.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= mstm_pkg::OP_NONE;
    end else if (in_accept) begin
      op_q <= mstm_pkg::op_e'(in_operation_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      bad_q      <= (in_delay_i < min_period_q) || (in_delay_i > max_period_q) ||
                    in_other_flags_i;
      now_q      <= in_now_i;
      delay_q    <= in_delay_i;
      periodic_q <= in_periodic_i;
      tag_q      <= in_user_tag_i;
      kill_id_q  <= in_kill_id_i;
    end
  end

  // Slot pointer and identifier counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      next_ident_q <= 32'd1;
    end else begin
      if (in_accept) begin
        idx_q <= '0;
      end else if (step) begin
        idx_q <= idx_q + 1'b1;
      end
      if (bump_id) begin
        next_ident_q <= (next_ident_inc == '0) ? 32'd1 : next_ident_inc;
      end
    end
  end

  // Held-back fire result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (take_pend) begin
      pend_valid_q <= 1'b1;
    end else if (clear_pend) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_pend) begin
      pend_id_q  <= view.ident;
      pend_tag_q <= view.tag;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q   <= out_kind_d;
      out_status_q <= out_status_d;
      out_id_q     <= out_id_d;
      out_tag_q    <= out_tag_d;
      out_last_q   <= out_last_d;
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mstm_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mstm_pkg::S_IDLE: begin
        if (in_accept && (mstm_pkg::op_e'(in_operation_i) != mstm_pkg::OP_NONE)) begin
          state_d = mstm_pkg::S_SCAN;
        end
      end
      mstm_pkg::S_SCAN: begin
        if (go_idle) begin
          state_d = mstm_pkg::S_IDLE;
        end else if (go_flush) begin
          state_d = mstm_pkg::S_FLUSH;
        end
      end
      mstm_pkg::S_FLUSH: begin
        if (go_idle) begin
          state_d = mstm_pkg::S_IDLE;
        end
      end
      default: state_d = mstm_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs: one slot is visited per cycle unless a result waits on the output.
  always_comb begin
    cmd          = '0;
    cmd.arm_mode = (op_q == mstm_pkg::OP_ARM);
    cmd.ident    = next_ident_q;
    out_load     = 1'b0;
    out_kind_d   = mstm_pkg::KIND_ARM;
    out_status_d = 1'b0;
    out_id_d     = '0;
    out_tag_d    = '0;
    out_last_d   = 1'b1;
    step         = 1'b0;
    go_flush     = 1'b0;
    go_idle      = 1'b0;
    take_pend    = 1'b0;
    clear_pend   = 1'b0;
    bump_id      = 1'b0;
    unique case (state_q)
      mstm_pkg::S_IDLE: ;
      mstm_pkg::S_SCAN: begin
        unique case (op_q)
          mstm_pkg::OP_ARM: begin
            out_kind_d = mstm_pkg::KIND_ARM;
            if (bad_q || (!view.free && last_slot)) begin
              // Rejected request or a full table.
              if (can_load) begin
                out_load     = 1'b1;
                out_status_d = 1'b1;
                go_idle      = 1'b1;
              end
            end else if (view.free) begin
              if (can_load) begin
                out_load   = 1'b1;
                out_id_d   = next_ident_q;
                cmd.wr_arm = 1'b1;
                bump_id    = 1'b1;
                go_idle    = 1'b1;
              end
            end else begin
              step = 1'b1;
            end
          end
          mstm_pkg::OP_KILL: begin
            out_kind_d = mstm_pkg::KIND_KILL;
            if (view.kill_hit) begin
              if (can_load) begin
                out_load    = 1'b1;
                cmd.wr_free = 1'b1;
                go_idle     = 1'b1;
              end
            end else if (last_slot) begin
              if (can_load) begin
                out_load     = 1'b1;
                out_status_d = 1'b1;
                go_idle      = 1'b1;
              end
            end else begin
              step = 1'b1;
            end
          end
          mstm_pkg::OP_SERVICE: begin
            if (view.due) begin
              // A new due slot releases the previous one as a non-final result.
              if (!pend_valid_q || can_load) begin
                if (pend_valid_q) begin
                  out_load   = 1'b1;
                  out_kind_d = mstm_pkg::KIND_FIRE;
                  out_id_d   = pend_id_q;
                  out_tag_d  = pend_tag_q;
                  out_last_d = 1'b0;
                end
                take_pend = 1'b1;
                if (view.repeats) begin
                  cmd.wr_rearm = 1'b1;
                end else begin
                  cmd.wr_free = 1'b1;
                end
                if (last_slot) begin
                  go_flush = 1'b1;
                end else begin
                  step = 1'b1;
                end
              end
            end else if (last_slot) begin
              go_flush = 1'b1;
            end else begin
              step = 1'b1;
            end
          end
          default: go_idle = 1'b1;
        endcase
      end
      mstm_pkg::S_FLUSH: begin
        // Final result of a service scan.
        if (can_load) begin
          out_load   = 1'b1;
          go_idle    = 1'b1;
          clear_pend = 1'b1;
          if (pend_valid_q) begin
            out_kind_d = mstm_pkg::KIND_FIRE;
            out_id_d   = pend_id_q;
            out_tag_d  = pend_tag_q;
          end else begin
            out_kind_d = mstm_pkg::KIND_EMPTY;
          end
        end
      end
      default: ;
    endcase
  end

  // Arm and kill replies are always the only result of their request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_kind_o == mstm_pkg::KIND_ARM) ||
                    (out_kind_o == mstm_pkg::KIND_KILL)) |-> out_last_o)
    else $error("arm or kill reply without last");

  // A successful arm hands out a nonzero identifier.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_kind_o == mstm_pkg::KIND_ARM) && !out_status_o
      |-> (out_timer_id_o != '0))
    else $error("arm succeeded with identifier zero");

  // Fire results carry a nonzero identifier and success.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_kind_o == mstm_pkg::KIND_FIRE)
      |-> (out_timer_id_o != '0) && !out_status_o)
    else $error("malformed fire result");

  // A held-back fire result never survives the end of a service scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (state_q != mstm_pkg::S_IDLE))
    else $error("pending fire result left behind");

  // The identifier counter never holds zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_ident_q != '0)
    else $error("next identifier is zero");

endmodule

`default_nettype wire

FILE: rtl/mstm_table.sv
`default_nettype none

module mstm_table (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire  [mstm_pkg::IdxW-1:0]          idx_i,
  input  wire  mstm_pkg::tbl_cmd_t           cmd_i,
  input  wire  [mstm_pkg::TimeW-1:0]         now_i,
  input  wire  [mstm_pkg::DelayW-1:0]        delay_i,
  input  wire                                periodic_i,
  input  wire  [mstm_pkg::TimeW-1:0]         tag_i,
  input  wire  [mstm_pkg::TimeW-1:0]         kill_id_i,
  output mstm_pkg::tbl_view_t                view_o
);

  logic [mstm_pkg::TimeW-1:0]  ident_q    [mstm_pkg::Slots];
  logic [mstm_pkg::TimeW-1:0]  tag_q      [mstm_pkg::Slots];
  logic [mstm_pkg::DelayW-1:0] period_q   [mstm_pkg::Slots];
  logic [mstm_pkg::TimeW-1:0]  deadline_q [mstm_pkg::Slots];
  logic                        repeats_q  [mstm_pkg::Slots];

  logic [mstm_pkg::TimeW-1:0]  cur_ident;
  logic [mstm_pkg::DelayW-1:0] add_b;
  logic [mstm_pkg::TimeW-1:0]  sum;
  logic [mstm_pkg::TimeW-1:0]  diff;

  // Shared arithmetic: one subtract for the due test, one add for new deadlines.
  assign cur_ident = ident_q[idx_i];
  assign add_b     = cmd_i.arm_mode ? delay_i : period_q[idx_i];
  assign sum       = now_i + {{(mstm_pkg::TimeW - mstm_pkg::DelayW){1'b0}}, add_b};
  assign diff      = now_i - deadline_q[idx_i];

  always_comb begin
    view_o          = '0;
    view_o.free     = (cur_ident == '0);
    view_o.kill_hit = (cur_ident != '0) && (cur_ident == kill_id_i);
    view_o.due      = (cur_ident != '0) && !diff[mstm_pkg::TimeW-1];
    view_o.repeats  = repeats_q[idx_i];
    view_o.ident    = cur_ident;
    view_o.tag      = tag_q[idx_i];
  end

  // Slot identifiers; zero marks a free slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mstm_pkg::Slots; i++) begin
        ident_q[i] <= '0;
      end
    end else if (cmd_i.wr_arm) begin
      ident_q[idx_i] <= cmd_i.ident;
    end else if (cmd_i.wr_free) begin
      ident_q[idx_i] <= '0;
    end
  end

  // Slot payload, valid only while the slot holds an identifier.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_arm) begin
      tag_q[idx_i]      <= tag_i;
      period_q[idx_i]   <= delay_i;
      deadline_q[idx_i] <= sum;
      repeats_q[idx_i]  <= periodic_i;
    end else if (cmd_i.wr_rearm) begin
      deadline_q[idx_i] <= sum;
    end
  end

endmodule

`default_nettype wire
